>>> src/ict_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_pkg
// shared types and constants of the inflight claim table
// ----------------------------------------------------------------------------
package ict_pkg;

   localparam int unsigned IDX_W  = 10;   // slot index, up to 1024 entries
   localparam int unsigned CNT_W  = 11;   // entry count, up to 1024
   localparam int unsigned KEY_W  = 256;
   localparam int unsigned LEG_W  = 8;
   localparam int unsigned TIME_W = 48;
   localparam int unsigned STAT_W = 32;
   localparam int unsigned STALE_W = 16;
   localparam logic [15:0] STALE_RESET = 16'd60;

   typedef enum logic [1:0] {
      ACT_CLAIM       = 2'd0,
      ACT_RELEASE     = 2'd1,
      ACT_RELEASE_LEG = 2'd2,
      ACT_QUERY       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [KEY_W-1:0]   key;
      logic [LEG_W-1:0]   leg;
      logic [TIME_W-1:0]  now;
   } cmd_type;

   // scan token handed from cell to cell
   typedef struct packed {
      logic               active;
      logic               found;
      logic               granted;
      logic               refused;
      logic               claimed;
      logic               free_found;
      logic [IDX_W-1:0]   free_idx;
      logic [IDX_W-1:0]   oldest_idx;
      logic [TIME_W-1:0]  oldest_time;
      logic [CNT_W-1:0]   occ;
      logic [CNT_W-1:0]   released;
   } token_type;

endpackage

>>> src/ict_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_if
// request and response channels of the inflight claim table
// ----------------------------------------------------------------------------
interface ict_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [63:0] key_0;
   logic [63:0] key_1;
   logic [63:0] key_2;
   logic [63:0] key_3;
   logic [7:0]  owner_leg;
   logic [47:0] now_seconds;

   modport source (output valid, action, key_0, key_1, key_2, key_3, owner_leg,
                   now_seconds, input ready);
   modport sink   (input valid, action, key_0, key_1, key_2, key_3, owner_leg,
                   now_seconds, output ready);
endinterface

interface ict_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [6:0]  occupancy;
   logic [31:0] refused_total;
   logic [31:0] claims_total;
   logic [31:0] released_total;

   modport source (output valid, granted, occupancy, refused_total, claims_total,
                   released_total, input ready);
   modport sink   (input valid, granted, occupancy, refused_total, claims_total,
                   released_total, output ready);
endinterface

>>> src/inflight_claim_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inflight_claim_table
// claim table with owner legs, stale takeover and saturating statistics
// ----------------------------------------------------------------------------
//  channel   dir   transfer
//  req_ch    in    one action: claim, release key, release leg, query
//  rsp_ch    out   one result per action: granted, occupancy, counters
//  csr_*     in    apb register port, stale_seconds at offset 0
//
//  a response is valid once the scan token has walked the cell chain
//  one entry per cycle and its result is registered; a new request is
//  taken only once the previous scan has finished, so a new action is
//  not accepted while another is still being scanned.
//  reset clears all valid marks and counters at once, no clearing pass.
//  a stalled response holds; the next request may still be taken and
//  scanned while it waits
// ----------------------------------------------------------------------------
module inflight_claim_table #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   ict_req_if.sink     req_ch,
   ict_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);

   ict_pkg::state_type                 state_ff, state_in;
   ict_pkg::cmd_type                   cmd_ff;
   logic                               start_ff;
   logic [ict_pkg::STALE_W-1:0]        stale_ff;
   ict_pkg::token_type                 tok [0:TABLE_ENTRIES];
   ict_pkg::token_type                 fin_ff;
   logic                               req_acc;
   logic                               fin_go;
   logic                               new_key;
   logic                               wr_en;
   logic [IW-1:0]                      wr_idx;
   logic [ict_pkg::STAT_W-1:0]         refused_ff, claims_ff, released_ff;
   logic [ict_pkg::STAT_W:0]           rel_sum;
   logic                               rsp_valid_ff;
   logic                               granted_ff;
   logic [6:0]                         occ_ff;
   logic [ict_pkg::CNT_W-1:0]          occ_next;

   // register port, one register so every offset maps to it
   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, stale_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ff <= ict_pkg::STALE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr <= 2'd3) begin
         stale_ff <= csr_pwdata[15:0];
      end
   end

   // sequencer
   assign req_acc = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ict_pkg::ST_IDLE: if (req_ch.valid) state_in = ict_pkg::ST_SCAN;
         ict_pkg::ST_SCAN: if (tok[TABLE_ENTRIES].active) state_in = ict_pkg::ST_FIN;
         ict_pkg::ST_FIN:  if (fin_go) state_in = ict_pkg::ST_IDLE;
         default:          state_in = ict_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      fin_go       = 1'b0;
      unique case (state_ff)
         ict_pkg::ST_IDLE: req_ch.ready = 1'b1;
         ict_pkg::ST_SCAN: req_ch.ready = 1'b0;
         ict_pkg::ST_FIN:  fin_go = !rsp_valid_ff || rsp_ch.ready;
         default:          req_ch.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ict_pkg::ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_acc;
      end
   end

   // command held steady for the whole scan
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff.action <= ict_pkg::action_type'(req_ch.action);
         cmd_ff.key    <= {req_ch.key_3, req_ch.key_2, req_ch.key_1, req_ch.key_0};
         cmd_ff.leg    <= req_ch.owner_leg;
         cmd_ff.now    <= req_ch.now_seconds;
      end
   end

   // token launch into the first cell
   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ict_cell #(.IDX(i), .IW(IW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd_ff),
         .stale   (stale_ff),
         .tok_in  (tok[i]),
         .wr_en   (wr_en),
         .wr_idx  (wr_idx),
         .tok_out (tok[i+1])
      );
   end

   // tail of the chain, held until the response slot frees up
   always_ff @(posedge clock) begin
      if (tok[TABLE_ENTRIES].active) begin
         fin_ff <= tok[TABLE_ENTRIES];
      end
   end

   // a claim on an unknown key lands in the lowest free slot, else the oldest
   assign new_key  = (cmd_ff.action == ict_pkg::ACT_CLAIM) && !fin_ff.found;
   assign wr_en    = fin_go && new_key;
   assign wr_idx   = fin_ff.free_found ? fin_ff.free_idx[IW-1:0]
                                       : fin_ff.oldest_idx[IW-1:0];
   assign occ_next = fin_ff.occ + {{(ict_pkg::CNT_W-1){1'b0}},
                                   (new_key && fin_ff.free_found)};
   assign rel_sum  = {1'b0, released_ff} +
                     (ict_pkg::STAT_W+1)'(fin_ff.released);

   // statistics, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         refused_ff  <= '0;
         claims_ff   <= '0;
         released_ff <= '0;
      end else if (fin_go) begin
         if (fin_ff.refused && refused_ff != '1) refused_ff <= refused_ff + 1'b1;
         if ((fin_ff.claimed || new_key) && claims_ff != '1) begin
            claims_ff <= claims_ff + 1'b1;
         end
         released_ff <= rel_sum[ict_pkg::STAT_W] ? '1 : rel_sum[ict_pkg::STAT_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin_go) begin
         granted_ff <= fin_ff.granted || new_key;
         occ_ff     <= 7'(occ_next);
      end
   end

   always_comb begin
      rsp_ch.valid          = rsp_valid_ff;
      rsp_ch.granted        = granted_ff;
      rsp_ch.occupancy      = occ_ff;
      rsp_ch.refused_total  = refused_ff;
      rsp_ch.claims_total   = claims_ff;
      rsp_ch.released_total = released_ff;
   end

`ifndef SYNTH
   // the token only leaves the chain during a scan
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[TABLE_ENTRIES].active |-> state_ff == ict_pkg::ST_SCAN)
      else $error("scan token left the chain outside a scan");

   // an accepted request launches a scan
   a_start_scan: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (start_ff && state_ff == ict_pkg::ST_SCAN))
      else $error("request accepted without a scan launch");

   // occupancy never exceeds the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> occ_ff <= 7'(TABLE_ENTRIES))
      else $error("occupancy beyond table size");
`endif

endmodule

>>> src/ict_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ict_cell
// one table entry; acts on the scan token as it passes and forwards it
// ----------------------------------------------------------------------------
module ict_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned IW  = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ict_pkg::cmd_type              cmd,
   input  logic [ict_pkg::STALE_W-1:0]   stale,
   input  ict_pkg::token_type            tok_in,
   input  logic                          wr_en,
   input  logic [IW-1:0]                 wr_idx,
   output ict_pkg::token_type            tok_out
);

   logic                               valid_ff, valid_in;
   logic [ict_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [ict_pkg::LEG_W-1:0]          owner_ff, owner_in;
   logic [ict_pkg::TIME_W-1:0]         time_ff, time_in;
   ict_pkg::token_type                 tok_ff, tok_in_nx;
   logic                               match;
   logic                               too_young;
   logic [ict_pkg::TIME_W:0]           diff;

   assign match = valid_ff && (key_ff == cmd.key);
   assign diff  = {1'b0, cmd.now} - {1'b0, time_ff};
   // time running backwards counts as young
   assign too_young = diff[ict_pkg::TIME_W] ||
                      (diff[ict_pkg::TIME_W-1:0] <
                       {{(ict_pkg::TIME_W-ict_pkg::STALE_W){1'b0}}, stale});

   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      owner_in  = owner_ff;
      time_in   = time_ff;
      tok_in_nx = tok_in;
      if (tok_in.active) begin
         case (cmd.action)
            ict_pkg::ACT_CLAIM: begin
               if (match) begin
                  tok_in_nx.found = 1'b1;
                  if (owner_ff == cmd.leg) begin
                     tok_in_nx.granted = 1'b1;
                  end else if (too_young) begin
                     tok_in_nx.refused = 1'b1;
                  end else begin
                     owner_in          = cmd.leg;
                     time_in           = cmd.now;
                     tok_in_nx.granted = 1'b1;
                     tok_in_nx.claimed = 1'b1;
                  end
               end
            end
            ict_pkg::ACT_RELEASE: begin
               if (match) begin
                  valid_in           = 1'b0;
                  tok_in_nx.released = tok_in.released + 1'b1;
               end
            end
            ict_pkg::ACT_RELEASE_LEG: begin
               if (valid_ff && owner_ff == cmd.leg) begin
                  valid_in           = 1'b0;
                  tok_in_nx.released = tok_in.released + 1'b1;
               end
            end
            default: begin
            end
         endcase
         // lowest free slot
         if (!valid_ff && !tok_in.free_found) begin
            tok_in_nx.free_found = 1'b1;
            tok_in_nx.free_idx   = ict_pkg::IDX_W'(IDX);
         end
         // oldest entry, first on ties
         if (IDX == 0 || time_ff < tok_in.oldest_time) begin
            tok_in_nx.oldest_time = time_ff;
            tok_in_nx.oldest_idx  = ict_pkg::IDX_W'(IDX);
         end
         tok_in_nx.occ = tok_in.occ + {{(ict_pkg::CNT_W-1){1'b0}}, valid_in};
      end
      if (wr_en && wr_idx == IW'(IDX)) begin
         valid_in = 1'b1;
         key_in   = cmd.key;
         owner_in = cmd.leg;
         time_in  = cmd.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         time_ff       <= '0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         time_ff       <= time_in;
         tok_ff.active <= tok_in_nx.active;
      end
      key_ff                   <= key_in;
      owner_ff                 <= owner_in;
      tok_ff[$bits(tok_ff)-2:0] <= tok_in_nx[$bits(tok_ff)-2:0];
   end

   assign tok_out = tok_ff;

endmodule
